>>> rtl/core/dfd_pkg.sv
// Shared types and constants for the deauthentication flood detector.
package dfd_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_POS_W     = $clog2(MAX_CHANNELS);

   localparam logic [11:0] MIN_FRAME_LEN = 12'd24;
   localparam logic [7:0]  FC_DEAUTH     = 8'hC0;
   localparam logic [7:0]  FC_DISASSOC   = 8'hA0;

   localparam logic        OP_FRAME = 1'b0;
   localparam logic        OP_TICK  = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DWELL_MS          = 3'd0,
      CSR_RATE_THRESHOLD    = 3'd1,
      CSR_CONFIRM_INTERVALS = 3'd2,
      CSR_CHANNEL_COUNT     = 3'd3,
      CSR_CHANNEL_LIST      = 3'd4
   } csr_index_type;

   localparam logic [9:0]  RST_DWELL_MS          = 10'd140;
   localparam logic [15:0] RST_RATE_THRESHOLD    = 16'd5;
   localparam logic [7:0]  RST_CONFIRM_INTERVALS = 8'd1;
   localparam logic [3:0]  RST_CHANNEL_COUNT     = 4'd3;
   localparam logic [63:0] RST_CHANNEL_LIST      = 64'h0000_0000_000B_0601;

   typedef struct packed {
      logic [9:0]  dwell_ms;
      logic [15:0] rate_threshold;
      logic [7:0]  confirm_intervals;
      logic [3:0]  channel_count;
      logic [63:0] channel_list;
   } cfg_type;

   typedef struct packed {
      logic [15:0]         frame_count;
      logic [15:0]         attack_run;
      logic [12:0]         interval_timer;
      logic [9:0]          hop_timer;
      logic [CH_POS_W-1:0] channel_position;
      logic [47:0]         last_transmitter;
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [11:0] frame_length;
      logic [7:0]  frame_control;
      logic [47:0] transmitter_mac;
   } req_item_type;

   typedef struct packed {
      logic        frame_counted;
      logic        interval_done;
      logic [15:0] interval_frames;
      logic        alarm_raised;
      logic        alarm_cleared;
      logic        channel_hop;
      logic [7:0]  channel;
      logic [47:0] suspect_mac;
   } rsp_item_type;

endpackage

>>> rtl/core/dfd_req_if.sv
// Request channel: frame and tick items.
interface dfd_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [11:0] frame_length;
   logic [7:0]  frame_control;
   logic [47:0] transmitter_mac;

   modport source (output valid, opcode, frame_length, frame_control, transmitter_mac,
                   input ready);
   modport sink   (input valid, opcode, frame_length, frame_control, transmitter_mac,
                   output ready);
endinterface

>>> rtl/core/dfd_rsp_if.sv
// Response channel: one result item per request item.
interface dfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_counted;
   logic        interval_done;
   logic [15:0] interval_frames;
   logic        alarm_raised;
   logic        alarm_cleared;
   logic        channel_hop;
   logic [7:0]  channel;
   logic [47:0] suspect_mac;

   modport source (output valid, frame_counted, interval_done, interval_frames,
                   alarm_raised, alarm_cleared, channel_hop, channel, suspect_mac,
                   input ready);
   modport sink   (input valid, frame_counted, interval_done, interval_frames,
                   alarm_raised, alarm_cleared, channel_hop, channel, suspect_mac,
                   output ready);
endinterface

>>> rtl/core/dfd_step.sv
// Per-item update: next detector state and the result item.
module dfd_step (
   input  dfd_pkg::cfg_type      cfg,
   input  dfd_pkg::state_type    cur,
   input  dfd_pkg::req_item_type item,
   output dfd_pkg::state_type    nxt,
   output dfd_pkg::rsp_item_type result
);

   function automatic logic [dfd_pkg::CH_POS_W-1:0] wrap_pos(
      input logic [dfd_pkg::CH_POS_W-1:0] pos,
      input logic [3:0]                   count
   );
      logic [3:0] p;
      p = {1'b0, pos} + 4'd1;
      // p <= 8 and count >= 2, so four compare-subtracts finish the modulo
      for (int i = 0; i < 4; i++) begin
         if (p >= count) begin
            p = p - count;
         end
      end
      return p[dfd_pkg::CH_POS_W-1:0];
   endfunction

   logic [9:0]  dwell_eff;
   logic [3:0]  count_eff;
   logic [7:0]  confirm_eff;
   logic [13:0] target;
   logic        is_tick;
   logic        counted;
   logic [15:0] frame_inc;
   logic [12:0] timer_inc;
   logic        close;
   logic        hot;
   logic [15:0] run_inc;
   logic [15:0] run_next;
   logic [9:0]  hop_inc;
   logic        hop;
   logic [dfd_pkg::CH_POS_W-1:0] pos_next;

   assign dwell_eff   = (cfg.dwell_ms == 10'd0) ? 10'd1 : cfg.dwell_ms;
   assign count_eff   = (cfg.channel_count == 4'd0) ? 4'd1 :
                        (cfg.channel_count > 4'(dfd_pkg::MAX_CHANNELS)) ?
                        4'(dfd_pkg::MAX_CHANNELS) : cfg.channel_count;
   assign confirm_eff = (cfg.confirm_intervals == 8'd0) ? 8'd1 : cfg.confirm_intervals;
   assign target      = {10'd0, count_eff} * {4'd0, dwell_eff};

   assign is_tick = (item.opcode == dfd_pkg::OP_TICK);

   // frame path
   assign counted = !is_tick && (item.frame_length >= dfd_pkg::MIN_FRAME_LEN) &&
                    ((item.frame_control == dfd_pkg::FC_DEAUTH) ||
                     (item.frame_control == dfd_pkg::FC_DISASSOC));
   assign frame_inc = (cur.frame_count != 16'hFFFF) ? cur.frame_count + 16'd1
                                                    : cur.frame_count;

   // interval path
   assign timer_inc = (cur.interval_timer != 13'h1FFF) ? cur.interval_timer + 13'd1
                                                       : cur.interval_timer;
   assign close     = is_tick && ({1'b0, timer_inc} >= target);
   assign hot       = (cur.frame_count >= cfg.rate_threshold);
   assign run_inc   = (cur.attack_run != 16'hFFFF) ? cur.attack_run + 16'd1
                                                   : cur.attack_run;
   assign run_next  = hot ? run_inc : 16'd0;

   // hop path
   assign hop_inc  = (cur.hop_timer != 10'h3FF) ? cur.hop_timer + 10'd1 : cur.hop_timer;
   assign hop      = is_tick && (count_eff > 4'd1) && (hop_inc >= dwell_eff);
   assign pos_next = hop ? wrap_pos(cur.channel_position, count_eff) : cur.channel_position;

   always_comb begin
      nxt = cur;
      if (is_tick) begin
         nxt.interval_timer = close ? 13'd0 : timer_inc;
         if (close) begin
            nxt.frame_count = 16'd0;
            nxt.attack_run  = run_next;
         end
         nxt.hop_timer        = hop ? 10'd0 : hop_inc;
         nxt.channel_position = pos_next;
      end else if (counted) begin
         nxt.frame_count      = frame_inc;
         nxt.last_transmitter = item.transmitter_mac;
      end
   end

   always_comb begin
      result.frame_counted   = counted;
      result.interval_done   = close;
      result.interval_frames = close ? cur.frame_count : 16'd0;
      result.alarm_raised    = close && (run_next == {8'd0, confirm_eff});
      result.alarm_cleared   = close && !hot && (cur.attack_run >= {8'd0, confirm_eff});
      result.channel_hop     = hop;
      result.channel         = cfg.channel_list[{pos_next, 3'b000} +: 8];
      result.suspect_mac     = nxt.last_transmitter;
   end

endmodule

>>> rtl/core/deauth_flood_detector_core.sv
// Top level of the deauthentication flood detector.
//
//   channel   dir  handshake      carries
//   req_chan  in   valid/ready    opcode, frame_length, frame_control, transmitter_mac
//   rsp_chan  out  valid/ready    one result item per request item
//   csr_*     in   csr_we strobe  register index and 64-bit write data, write only
//
// One item per cycle: the update of counters, timers and channel position is a
// single pass of narrow add, multiply and compare logic from the state registers
// to the result register; each result is offered in the cycle after acceptance.
// Reset (synchronous) returns registers to their defaults and empties the result.
// A waiting result only blocks input while rsp_chan stalls; an item is taken in
// the same cycle that the held result is taken.
module deauth_flood_detector_core (
   input  logic                                    clock,
   input  logic                                    reset,
   dfd_req_if.sink                                 req_chan,
   dfd_rsp_if.source                               rsp_chan,
   input  logic                                    csr_we,
   input  logic [dfd_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [dfd_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   dfd_pkg::cfg_type      cfg_ff;
   dfd_pkg::cfg_type      cfg_in;
   dfd_pkg::state_type    state_ff;
   dfd_pkg::state_type    state_in;
   dfd_pkg::req_item_type item;
   dfd_pkg::rsp_item_type result;
   dfd_pkg::rsp_item_type rsp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  accept;

   // --- configuration registers ---
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (dfd_pkg::csr_index_type'(csr_index))
            dfd_pkg::CSR_DWELL_MS:          cfg_in.dwell_ms          = csr_wdata[9:0];
            dfd_pkg::CSR_RATE_THRESHOLD:    cfg_in.rate_threshold    = csr_wdata[15:0];
            dfd_pkg::CSR_CONFIRM_INTERVALS: cfg_in.confirm_intervals = csr_wdata[7:0];
            dfd_pkg::CSR_CHANNEL_COUNT:     cfg_in.channel_count     = csr_wdata[3:0];
            dfd_pkg::CSR_CHANNEL_LIST:      cfg_in.channel_list      = csr_wdata;
            default:                        cfg_in = cfg_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dwell_ms          <= dfd_pkg::RST_DWELL_MS;
         cfg_ff.rate_threshold    <= dfd_pkg::RST_RATE_THRESHOLD;
         cfg_ff.confirm_intervals <= dfd_pkg::RST_CONFIRM_INTERVALS;
         cfg_ff.channel_count     <= dfd_pkg::RST_CHANNEL_COUNT;
         cfg_ff.channel_list      <= dfd_pkg::RST_CHANNEL_LIST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --- handshake: take an item whenever the result slot is free or draining ---
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign item.opcode          = req_chan.opcode;
   assign item.frame_length    = req_chan.frame_length;
   assign item.frame_control   = req_chan.frame_control;
   assign item.transmitter_mac = req_chan.transmitter_mac;

   dfd_step u_step (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (item),
      .nxt    (state_in),
      .result (result)
   );

   assign rsp_valid_in = accept ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // detector state: all counters, timers and latched MAC clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.frame_counted   = rsp_ff.frame_counted;
   assign rsp_chan.interval_done   = rsp_ff.interval_done;
   assign rsp_chan.interval_frames = rsp_ff.interval_frames;
   assign rsp_chan.alarm_raised    = rsp_ff.alarm_raised;
   assign rsp_chan.alarm_cleared   = rsp_ff.alarm_cleared;
   assign rsp_chan.channel_hop     = rsp_ff.channel_hop;
   assign rsp_chan.channel         = rsp_ff.channel;
   assign rsp_chan.suspect_mac     = rsp_ff.suspect_mac;

endmodule

>>> rtl/core/dfd_checker.sv
// Port-level assertions for the detector, bound to the top level.
module dfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        frame_counted,
   input logic        interval_done,
   input logic [15:0] interval_frames,
   input logic        alarm_raised,
   input logic        alarm_cleared,
   input logic        channel_hop
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(interval_frames) &&
      $stable(frame_counted))
      else $error("result changed while stalled");

   // frame results never carry tick events
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_counted |-> !interval_done && !channel_hop)
      else $error("frame item reported tick events");

   // attack edges and frame totals only on closed intervals, never both edges
   a_attack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (alarm_raised || alarm_cleared || interval_frames != 16'd0)
      |-> interval_done && !(alarm_raised && alarm_cleared))
      else $error("attack report outside interval close");

   // reset empties the result slot
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind deauth_flood_detector_core dfd_checker u_dfd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .frame_counted   (rsp_chan.frame_counted),
   .interval_done   (rsp_chan.interval_done),
   .interval_frames (rsp_chan.interval_frames),
   .alarm_raised    (rsp_chan.alarm_raised),
   .alarm_cleared   (rsp_chan.alarm_cleared),
   .channel_hop     (rsp_chan.channel_hop)
);
